@@ rtl/core/ibfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ibfp_pkg
// Shared types and constants for the serial RC frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibfp_pkg;

  localparam logic [7:0]  HDR0      = 8'h20;
  localparam logic [7:0]  HDR1      = 8'h40;
  localparam logic [15:0] CK_INIT   = 16'hFF9F;
  localparam logic [4:0]  POS_HUNT  = 5'd0;
  localparam logic [4:0]  POS_HDR1  = 5'd1;
  localparam logic [4:0]  POS_FIRST = 5'd2;
  localparam logic [4:0]  POS_CK_LO = 5'd30;
  localparam logic [4:0]  POS_CK_HI = 5'd31;

  // controller -> datapath
  typedef struct packed {
    logic byte_en;   // a byte beat is accepted this cycle
    logic ch_clear;  // restart the channel counter
    logic rd_req;    // read the current channel word into the output register
    logic ch_adv;    // step to the next channel
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_ok;  // last byte of a frame with a matching checksum
    logic out_last;  // output register holds the final channel
  } status_t;

endpackage

@@ rtl/core/ibfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ibfp_ctrl
// Sequencer: receive bytes, then read out and hand over channel words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ibfp_pkg::status_t status,
  output ibfp_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_RX   = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_RX);
  assign m_tvalid = (state == S_OUT);

  always_comb begin
    state_next   = state;
    cmd.byte_en  = 1'b0;
    cmd.ch_clear = 1'b0;
    cmd.rd_req   = 1'b0;
    cmd.ch_adv   = 1'b0;
    case (state)
      S_RX: begin
        cmd.byte_en = s_tvalid;
        if (status.frame_ok) begin
          cmd.ch_clear = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_req = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) begin
          if (status.out_last) begin
            state_next = S_RX;
          end else begin
            cmd.ch_adv = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RX;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/ibfp_datapath.sv @@
// ----------------------------------------------------------------------------
// ibfp_datapath
// Byte position, running checksum, channel word store and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibfp_datapath #(
  parameter int CHANNELS = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  ibfp_pkg::cmd_t    cmd,
  output ibfp_pkg::status_t status,
  output logic [3:0]        channel_index,
  output logic [15:0]       channel_value,
  output logic              last_channel
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] CH_COUNT = 4'(CHANNELS);
  localparam logic [3:0] CH_LAST  = 4'(CHANNELS - 1);

  logic [4:0]  pos;
  logic [15:0] cksum;
  logic [7:0]  lo_byte;
  logic [7:0]  ck_lo;
  logic [3:0]  ch;
  logic [15:0] word_mem [CHANNELS];
  logic [3:0]  widx;
  logic        wr_en;

  // bytes 2k and 2k+1 form channel word k-1
  assign widx  = pos[4:1] - 4'd1;
  assign wr_en = cmd.byte_en && (pos >= ibfp_pkg::POS_FIRST) && (pos < ibfp_pkg::POS_CK_LO)
                 && pos[0] && (widx < CH_COUNT);

  assign status.frame_ok = cmd.byte_en && (pos == ibfp_pkg::POS_CK_HI)
                           && ({rx_byte, ck_lo} == cksum);
  assign status.out_last = last_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= ibfp_pkg::POS_HUNT;
      cksum <= ibfp_pkg::CK_INIT;
    end else if (cmd.byte_en) begin
      case (pos)
        ibfp_pkg::POS_HUNT: begin
          if (rx_byte == ibfp_pkg::HDR0) pos <= ibfp_pkg::POS_HDR1;
        end
        ibfp_pkg::POS_HDR1: begin
          // a bad second header byte is not retried as a first one
          if (rx_byte == ibfp_pkg::HDR1) begin
            pos   <= ibfp_pkg::POS_FIRST;
            cksum <= ibfp_pkg::CK_INIT;
          end else begin
            pos <= ibfp_pkg::POS_HUNT;
          end
        end
        ibfp_pkg::POS_CK_HI: pos <= ibfp_pkg::POS_HUNT;
        default: begin
          if (pos < ibfp_pkg::POS_CK_LO) cksum <= cksum - {8'd0, rx_byte};
          pos <= pos + 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en && !pos[0]) lo_byte <= rx_byte;
    if (cmd.byte_en && (pos == ibfp_pkg::POS_CK_LO)) ck_lo <= rx_byte;
    if (wr_en) word_mem[widx[AW-1:0]] <= {rx_byte, lo_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= 4'd0;
    end else if (cmd.ch_clear) begin
      ch <= 4'd0;
    end else if (cmd.ch_adv) begin
      ch <= ch + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      channel_value <= word_mem[ch[AW-1:0]];
      channel_index <= ch;
      last_channel  <= (ch == CH_LAST);
    end
  end

endmodule

@@ rtl/core/ibus_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ibus_frame_parser
// Finds 32-byte RC frames in a byte stream and emits their channel words.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and takes a new byte every cycle while a
// frame is being received. A frame opens with 0x20 0x40, carries CHANNELS
// little-endian words from byte 2 on, and closes with a little-endian
// checksum in bytes 30 and 31 (0xFFFF minus the sum of bytes 0..29). On a
// match the block stops taking bytes and sends CHANNELS output beats, one
// channel word each, the last with tlast set; each beat passes through a store
// read, then the output register, plus any wait on m_tready. A frame
// with a bad checksum is dropped with no output.
`timescale 1ns / 1ps

module ibus_frame_parser #(
  parameter int CHANNELS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] channel_index, [19:4] channel_value, [23:20] zero
  output logic        m_tlast    // last_channel
);

  ibfp_pkg::cmd_t    cmd;
  ibfp_pkg::status_t status;
  logic [3:0]        channel_index;
  logic [15:0]       channel_value;

  ibfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ibfp_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (s_tdata),
    .cmd           (cmd),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (m_tlast)
  );

  assign m_tdata = {4'd0, channel_value, channel_index};

endmodule
